### sv/rv32i_ieu_pkg.sv
// rv32i_ieu_pkg: types, opcodes and sizing constants shared by the execute unit
// used by the front decoder, the queue, the back end and the top level
`timescale 1ns / 1ps

package rv32i_ieu_pkg;

    // data memory sizing
    localparam int DMEM_WORDS = 1024;
    localparam int DMEM_AW    = $clog2(DMEM_WORDS);
    localparam logic [32:0] MEM_BYTES = 33'(DMEM_WORDS) << 2;

    // decoupling queue
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    // reset values
    localparam logic [31:0] RAM_BASE_RST = 32'h8000_0000;
    localparam logic [31:0] START_PC_RST = 32'h8000_0000;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PC = 1'b1;

    // major opcodes
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_FENCE  = 7'h0F;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    localparam logic [6:0] F7_ZERO = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // fault codes
    localparam logic [1:0] FLT_NONE = 2'd0;
    localparam logic [1:0] FLT_ILL  = 2'd1;
    localparam logic [1:0] FLT_ADDR = 2'd2;

    typedef enum logic [3:0] {
        K_LUI, K_AUIPC, K_JAL, K_JALR, K_BR, K_LD, K_ST,
        K_ALU, K_NOP, K_ILL, K_PRE
    } t_kind;

    typedef enum logic [3:0] {
        A_ADD, A_SUB, A_SLL, A_SLT, A_SLTU, A_XOR, A_SRL, A_SRA, A_OR, A_AND
    } t_alu_op;

    typedef struct packed {
        logic        mode;
        logic [31:0] instruction;
        logic [9:0]  preload_index;
        logic [31:0] preload_word;
    } t_in_item;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_written;
        logic [4:0]  dest_index;
        logic [31:0] dest_value;
        logic        store_done;
        logic [1:0]  fault;
    } t_out_item;

    // classified item between front and back
    typedef struct packed {
        t_kind       kind;
        t_alu_op     alu;
        logic [2:0]  f3;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
        logic        use_imm;
        logic [9:0]  pidx;
    } t_uop;

    // program counter load from the configuration port
    typedef struct packed {
        logic        load;
        logic [31:0] value;
    } t_pc_load;

endpackage

### sv/rv32i_ieu_front.sv
// rv32i_ieu_front: decodes an accepted transaction into a classified micro-op
// depends on rv32i_ieu_pkg
`timescale 1ns / 1ps

module rv32i_ieu_front (
    input  rv32i_ieu_pkg::t_in_item i_item,
    output rv32i_ieu_pkg::t_uop     o_uop
);

    logic [31:0] ins;
    logic [6:0]  op;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] immi;
    logic [31:0] imms;
    logic [31:0] immb;
    logic [31:0] immj;
    logic [31:0] immu;

    assign ins  = i_item.instruction;
    assign op   = ins[6:0];
    assign f3   = ins[14:12];
    assign f7   = ins[31:25];
    assign immi = {{20{ins[31]}}, ins[31:20]};
    assign imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    assign immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    assign immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    assign immu = {ins[31:12], 12'b0};

    always_comb begin
        o_uop         = '0;
        o_uop.kind    = rv32i_ieu_pkg::K_ILL;
        o_uop.alu     = rv32i_ieu_pkg::A_ADD;
        o_uop.f3      = f3;
        o_uop.rd      = ins[11:7];
        o_uop.rs1     = ins[19:15];
        o_uop.rs2     = ins[24:20];
        o_uop.imm     = immi;
        o_uop.use_imm = 1'b1;
        o_uop.pidx    = i_item.preload_index;
        if (i_item.mode) begin
            o_uop.kind = rv32i_ieu_pkg::K_PRE;
            o_uop.imm  = i_item.preload_word;
        end else begin
            unique case (op) inside
                rv32i_ieu_pkg::OP_LUI: begin
                    o_uop.kind = rv32i_ieu_pkg::K_LUI;
                    o_uop.imm  = immu;
                end
                rv32i_ieu_pkg::OP_AUIPC: begin
                    o_uop.kind = rv32i_ieu_pkg::K_AUIPC;
                    o_uop.imm  = immu;
                end
                rv32i_ieu_pkg::OP_JAL: begin
                    o_uop.kind = rv32i_ieu_pkg::K_JAL;
                    o_uop.imm  = immj;
                end
                rv32i_ieu_pkg::OP_JALR: begin
                    if (f3 == 3'd0) o_uop.kind = rv32i_ieu_pkg::K_JALR;
                end
                rv32i_ieu_pkg::OP_BRANCH: begin
                    o_uop.imm = immb;
                    if (f3 != 3'd2 && f3 != 3'd3) o_uop.kind = rv32i_ieu_pkg::K_BR;
                end
                rv32i_ieu_pkg::OP_LOAD: begin
                    if (f3 != 3'd3 && f3 <= 3'd5) o_uop.kind = rv32i_ieu_pkg::K_LD;
                end
                rv32i_ieu_pkg::OP_STORE: begin
                    o_uop.imm = imms;
                    if (f3 <= 3'd2) o_uop.kind = rv32i_ieu_pkg::K_ST;
                end
                rv32i_ieu_pkg::OP_IMM: begin
                    o_uop.kind = rv32i_ieu_pkg::K_ALU;
                    case (f3)
                        3'd0: o_uop.alu = rv32i_ieu_pkg::A_ADD;
                        3'd1: begin
                            o_uop.alu = rv32i_ieu_pkg::A_SLL;
                            if (f7 != rv32i_ieu_pkg::F7_ZERO) o_uop.kind = rv32i_ieu_pkg::K_ILL;
                        end
                        3'd2: o_uop.alu = rv32i_ieu_pkg::A_SLT;
                        3'd3: o_uop.alu = rv32i_ieu_pkg::A_SLTU;
                        3'd4: o_uop.alu = rv32i_ieu_pkg::A_XOR;
                        3'd5: begin
                            if (f7 == rv32i_ieu_pkg::F7_ZERO) begin
                                o_uop.alu = rv32i_ieu_pkg::A_SRL;
                            end else if (f7 == rv32i_ieu_pkg::F7_ALT) begin
                                o_uop.alu = rv32i_ieu_pkg::A_SRA;
                            end else begin
                                o_uop.kind = rv32i_ieu_pkg::K_ILL;
                            end
                        end
                        3'd6: o_uop.alu = rv32i_ieu_pkg::A_OR;
                        default: o_uop.alu = rv32i_ieu_pkg::A_AND;
                    endcase
                end
                rv32i_ieu_pkg::OP_REG: begin
                    o_uop.use_imm = 1'b0;
                    o_uop.kind    = rv32i_ieu_pkg::K_ALU;
                    if (f7 != rv32i_ieu_pkg::F7_ZERO &&
                        !(f7 == rv32i_ieu_pkg::F7_ALT && (f3 == 3'd0 || f3 == 3'd5))) begin
                        o_uop.kind = rv32i_ieu_pkg::K_ILL;
                    end
                    case (f3)
                        3'd0: o_uop.alu = (f7 == rv32i_ieu_pkg::F7_ALT) ?
                                          rv32i_ieu_pkg::A_SUB : rv32i_ieu_pkg::A_ADD;
                        3'd1: o_uop.alu = rv32i_ieu_pkg::A_SLL;
                        3'd2: o_uop.alu = rv32i_ieu_pkg::A_SLT;
                        3'd3: o_uop.alu = rv32i_ieu_pkg::A_SLTU;
                        3'd4: o_uop.alu = rv32i_ieu_pkg::A_XOR;
                        3'd5: o_uop.alu = (f7 == rv32i_ieu_pkg::F7_ALT) ?
                                          rv32i_ieu_pkg::A_SRA : rv32i_ieu_pkg::A_SRL;
                        3'd6: o_uop.alu = rv32i_ieu_pkg::A_OR;
                        default: o_uop.alu = rv32i_ieu_pkg::A_AND;
                    endcase
                end
                rv32i_ieu_pkg::OP_FENCE, rv32i_ieu_pkg::OP_SYSTEM: begin
                    o_uop.kind = rv32i_ieu_pkg::K_NOP;
                end
                default: o_uop.kind = rv32i_ieu_pkg::K_ILL;
            endcase
        end
    end

endmodule

### sv/rv32i_ieu_queue.sv
// rv32i_ieu_queue: short fifo of decoded micro-ops between front and back
// depends on rv32i_ieu_pkg
`timescale 1ns / 1ps

module rv32i_ieu_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  rv32i_ieu_pkg::t_uop  i_uop,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output rv32i_ieu_pkg::t_uop  o_uop
);

    rv32i_ieu_pkg::t_uop              r_q [rv32i_ieu_pkg::QDEPTH];
    logic [rv32i_ieu_pkg::QAW-1:0]    r_wp;
    logic [rv32i_ieu_pkg::QAW-1:0]    r_rp;
    logic [rv32i_ieu_pkg::QAW:0]      r_cnt;
    logic                             push_ok;
    logic                             pop_ok;

    assign o_full  = (r_cnt == (rv32i_ieu_pkg::QAW + 1)'(rv32i_ieu_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_uop   = r_q[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) r_q[r_wp] <= i_uop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) r_wp <= r_wp + 1'b1;
            if (pop_ok)  r_rp <= r_rp + 1'b1;
            if (push_ok && !pop_ok)      r_cnt <= r_cnt + 1'b1;
            else if (pop_ok && !push_ok) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

### sv/rv32i_ieu_back.sv
// rv32i_ieu_back: execute, write-back and output stages with register file,
// program counter and byte-banked data memory; depends on rv32i_ieu_pkg
`timescale 1ns / 1ps

module rv32i_ieu_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  rv32i_ieu_pkg::t_uop        i_q_uop,
    output logic                       o_q_pop,
    input  logic [31:0]                i_ram_base,
    input  rv32i_ieu_pkg::t_pc_load    i_pc_ld,
    output logic                       o_out_valid,
    output rv32i_ieu_pkg::t_out_item   o_out_item,
    input  logic                       i_out_ready
);

    localparam int AW = rv32i_ieu_pkg::DMEM_AW;

    typedef struct packed {
        logic        wr;
        logic [4:0]  rd;
        logic [31:0] val;
        logic [31:0] next_pc;
        logic        store;
        logic [1:0]  fault;
        logic        load;
        logic [1:0]  lsh;
        logic [2:0]  f3;
    } t_wb;

    logic                  adv;
    logic                  r_ex_v;
    rv32i_ieu_pkg::t_uop   r_ex;
    logic [31:0]           r_a;
    logic [31:0]           r_b;
    logic                  r_wb_v;
    t_wb                   r_wb;
    t_wb                   n_wb;
    logic                  r_out_v;
    rv32i_ieu_pkg::t_out_item r_out;
    logic [31:0]           r_pc;

    logic [31:0]           r_rf [32];
    logic [31:0]           r_rf_vld;
    logic [7:0]            r_mem [4][rv32i_ieu_pkg::DMEM_WORDS];
    logic [7:0]            r_rdat [4];

    logic                  rf_we;
    logic [31:0]           wb_val;
    logic [31:0]           ld_word;
    logic [31:0]           ld_val;
    logic [31:0]           a;
    logic [31:0]           b;
    logic [31:0]           op2;
    logic [31:0]           pc4;
    logic [31:0]           addr;
    logic [31:0]           off;
    logic [2:0]            size;
    logic                  in_rng;
    logic [31:0]           alu_res;
    logic                  taken;
    logic                  st_go;
    logic                  pre_go;
    logic [3:0]            bank_we;
    logic [AW-1:0]         bank_row [4];
    logic [7:0]            bank_wd [4];
    logic [31:0]           rs1_rd;
    logic [31:0]           rs2_rd;

    assign adv     = !r_out_v || i_out_ready;
    assign o_q_pop = adv;
    assign rf_we   = adv && r_wb_v && r_wb.wr;

    // load data assembly from the bank read registers
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            ld_word[8*k +: 8] = r_rdat[2'(r_wb.lsh + 2'(k))];
        end
        case (r_wb.f3)
            3'd0:    ld_val = {{24{ld_word[7]}}, ld_word[7:0]};
            3'd1:    ld_val = {{16{ld_word[15]}}, ld_word[15:0]};
            3'd4:    ld_val = {24'b0, ld_word[7:0]};
            3'd5:    ld_val = {16'b0, ld_word[15:0]};
            default: ld_val = ld_word;
        endcase
    end

    assign wb_val = r_wb.load ? ld_val : r_wb.val;

    // register read with write-through from the write-back stage
    assign rs1_rd = (r_wb_v && r_wb.wr && r_wb.rd == i_q_uop.rs1) ? wb_val :
                    (r_rf_vld[i_q_uop.rs1] ? r_rf[i_q_uop.rs1] : 32'd0);
    assign rs2_rd = (r_wb_v && r_wb.wr && r_wb.rd == i_q_uop.rs2) ? wb_val :
                    (r_rf_vld[i_q_uop.rs2] ? r_rf[i_q_uop.rs2] : 32'd0);

    // execute
    always_comb begin
        a = (r_wb_v && r_wb.wr && r_wb.rd == r_ex.rs1) ? wb_val : r_a;
        b = (r_wb_v && r_wb.wr && r_wb.rd == r_ex.rs2) ? wb_val : r_b;
        op2    = r_ex.use_imm ? r_ex.imm : b;
        pc4    = r_pc + 32'd4;
        addr   = a + r_ex.imm;
        off    = addr - i_ram_base;
        size   = (r_ex.f3[1:0] == 2'd0) ? 3'd1 : ((r_ex.f3[1:0] == 2'd1) ? 3'd2 : 3'd4);
        in_rng = ({1'b0, off} + 33'(size)) <= rv32i_ieu_pkg::MEM_BYTES;

        case (r_ex.alu)
            rv32i_ieu_pkg::A_SUB:  alu_res = a - op2;
            rv32i_ieu_pkg::A_SLL:  alu_res = a << op2[4:0];
            rv32i_ieu_pkg::A_SLT:  alu_res = {31'b0, $signed(a) < $signed(op2)};
            rv32i_ieu_pkg::A_SLTU: alu_res = {31'b0, a < op2};
            rv32i_ieu_pkg::A_XOR:  alu_res = a ^ op2;
            rv32i_ieu_pkg::A_SRL:  alu_res = a >> op2[4:0];
            rv32i_ieu_pkg::A_SRA:  alu_res = 32'($signed(a) >>> op2[4:0]);
            rv32i_ieu_pkg::A_OR:   alu_res = a | op2;
            rv32i_ieu_pkg::A_AND:  alu_res = a & op2;
            default:               alu_res = a + op2;
        endcase

        case (r_ex.f3)
            3'd0:    taken = (a == b);
            3'd1:    taken = (a != b);
            3'd4:    taken = $signed(a) < $signed(b);
            3'd5:    taken = $signed(a) >= $signed(b);
            3'd6:    taken = (a < b);
            default: taken = (a >= b);
        endcase

        n_wb         = '0;
        n_wb.rd      = r_ex.rd;
        n_wb.next_pc = pc4;
        n_wb.lsh     = off[1:0];
        n_wb.f3      = r_ex.f3;
        st_go        = 1'b0;
        pre_go       = 1'b0;
        unique case (r_ex.kind)
            rv32i_ieu_pkg::K_LUI: begin
                n_wb.val = r_ex.imm;
                n_wb.wr  = 1'b1;
            end
            rv32i_ieu_pkg::K_AUIPC: begin
                n_wb.val = r_pc + r_ex.imm;
                n_wb.wr  = 1'b1;
            end
            rv32i_ieu_pkg::K_JAL: begin
                n_wb.val     = pc4;
                n_wb.wr      = 1'b1;
                n_wb.next_pc = r_pc + r_ex.imm;
            end
            rv32i_ieu_pkg::K_JALR: begin
                n_wb.val     = pc4;
                n_wb.wr      = 1'b1;
                n_wb.next_pc = {addr[31:1], 1'b0};
            end
            rv32i_ieu_pkg::K_BR: begin
                if (taken) n_wb.next_pc = r_pc + r_ex.imm;
            end
            rv32i_ieu_pkg::K_LD: begin
                if (in_rng) begin
                    n_wb.wr   = 1'b1;
                    n_wb.load = 1'b1;
                end else begin
                    n_wb.fault   = rv32i_ieu_pkg::FLT_ADDR;
                    n_wb.next_pc = r_pc;
                end
            end
            rv32i_ieu_pkg::K_ST: begin
                if (in_rng) begin
                    n_wb.store = 1'b1;
                    st_go      = r_ex_v;
                end else begin
                    n_wb.fault   = rv32i_ieu_pkg::FLT_ADDR;
                    n_wb.next_pc = r_pc;
                end
            end
            rv32i_ieu_pkg::K_ALU: begin
                n_wb.val = alu_res;
                n_wb.wr  = 1'b1;
            end
            rv32i_ieu_pkg::K_NOP: begin
                n_wb.next_pc = pc4;
            end
            rv32i_ieu_pkg::K_PRE: begin
                n_wb.next_pc = r_pc;
                n_wb.rd      = 5'd0;
                pre_go       = r_ex_v &&
                               ({22'b0, r_ex.pidx} < 32'(rv32i_ieu_pkg::DMEM_WORDS));
            end
            default: begin
                n_wb.fault   = rv32i_ieu_pkg::FLT_ILL;
                n_wb.next_pc = r_pc;
            end
        endcase
        if (r_ex.rd == 5'd0) n_wb.wr = 1'b0;
        if (!n_wb.wr) n_wb.rd = 5'd0;
    end

    // byte bank addressing: bank j holds the bytes whose offset from the ram base is j mod 4
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            if (pre_go) begin
                bank_row[j] = AW'(r_ex.pidx);
                bank_wd[j]  = r_ex.imm[8*j +: 8];
                bank_we[j]  = 1'b1;
            end else begin
                bank_row[j] = off[AW+1:2] + AW'(2'(j) < off[1:0]);
                bank_wd[j]  = b[{2'(2'(j) - off[1:0]), 3'b000} +: 8];
                bank_we[j]  = st_go && (3'(2'(2'(j) - off[1:0])) < size);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int j = 0; j < 4; j++) begin
                if (bank_we[j]) r_mem[j][bank_row[j]] <= bank_wd[j];
                r_rdat[j] <= r_mem[j][bank_row[j]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rf_we) r_rf[r_wb.rd] <= wb_val;
        if (adv) begin
            r_ex <= i_q_uop;
            r_a  <= rs1_rd;
            r_b  <= rs2_rd;
            r_wb <= n_wb;
            r_out.next_pc     <= r_wb.next_pc;
            r_out.reg_written <= r_wb.wr;
            r_out.dest_index  <= r_wb.rd;
            r_out.dest_value  <= r_wb.wr ? wb_val : 32'd0;
            r_out.store_done  <= r_wb.store;
            r_out.fault       <= r_wb.fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_v   <= 1'b0;
            r_wb_v   <= 1'b0;
            r_out_v  <= 1'b0;
            r_rf_vld <= '0;
            r_pc     <= rv32i_ieu_pkg::START_PC_RST;
        end else begin
            if (adv) begin
                r_ex_v  <= i_q_valid;
                r_wb_v  <= r_ex_v;
                r_out_v <= r_wb_v;
            end
            if (rf_we) r_rf_vld[r_wb.rd] <= 1'b1;
            if (i_pc_ld.load) r_pc <= i_pc_ld.value;
            else if (adv && r_ex_v) r_pc <= n_wb.next_pc;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_fault_no_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out.fault != rv32i_ieu_pkg::FLT_NONE
        |-> !r_out.reg_written && !r_out.store_done)
        else $error("faulting result reports a side effect");

    a_no_x0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_we |-> r_wb.rd != 5'd0)
        else $error("register write aimed at x0");

    a_pc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && !(adv && r_ex_v) && !i_pc_ld.load |=> $stable(r_pc))
        else $error("pc moved without an executed transaction");
`endif

endmodule

### sv/rv32i_integer_execute_unit.sv
// rv32i_integer_execute_unit: top level of the rv32i execute unit
// a result passes from the queue through the execute, write-back and output registers
// throughput: one transaction per cycle while the result side accepts, loads included
// (load data forwards from the bank read registers)
// reset: pc and ram_base go to 0x80000000, register file reads zero, queue and
// pipeline empty; data memory is not cleared and needs no clearing pass
`timescale 1ns / 1ps

module rv32i_integer_execute_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input transactions
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  rv32i_ieu_pkg::t_in_item                i_in_item,
    // result transactions
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output rv32i_ieu_pkg::t_out_item               o_out_item,
    // configuration writes
    input  logic                                   i_cfg_we,
    input  logic [rv32i_ieu_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [31:0]                            i_cfg_wdata
);

    rv32i_ieu_pkg::t_uop      dec_uop;
    rv32i_ieu_pkg::t_uop      q_uop;
    rv32i_ieu_pkg::t_pc_load  pc_ld;
    logic                     q_full;
    logic                     q_valid;
    logic                     q_pop;
    logic [31:0]              r_ram_base;

    // front: classify the transaction, straight into the queue
    rv32i_ieu_front u_front (
        .i_item (i_in_item),
        .o_uop  (dec_uop)
    );

    // queue decouples acceptance from back-end stalls on the result side
    rv32i_ieu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_uop   (dec_uop),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_uop   (q_uop)
    );

    assign o_in_ready = !q_full;

    // configuration: ram base is held here, a start pc write reloads the pc
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_base <= rv32i_ieu_pkg::RAM_BASE_RST;
        end else if (i_cfg_we && i_cfg_idx == rv32i_ieu_pkg::CFG_RAM_BASE) begin
            r_ram_base <= i_cfg_wdata;
        end
    end

    assign pc_ld.load  = i_cfg_we && (i_cfg_idx == rv32i_ieu_pkg::CFG_START_PC);
    assign pc_ld.value = i_cfg_wdata;

    // back: execute, write-back and the output register
    rv32i_ieu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_uop     (q_uop),
        .o_q_pop     (q_pop),
        .i_ram_base  (r_ram_base),
        .i_pc_ld     (pc_ld),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_ready (i_out_ready)
    );

endmodule

### sim/tb_rv32i_integer_execute_unit.sv
// tb_rv32i_integer_execute_unit: self-checking bench for the rv32i execute unit
// needs rv32i_ieu_pkg and rv32i_integer_execute_unit; reads no files
`timescale 1ns / 1ps

module tb_rv32i_integer_execute_unit;
    import rv32i_ieu_pkg::*;

    localparam int MEMB       = DMEM_WORDS * 4;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN_WAIT = 8;

    // ------------------------------------------------------------------
    // architectural shadow of the unit plus the queue of awaited results
    // ------------------------------------------------------------------
    class exec_scoreboard;
        bit [31:0] regs [32];
        bit [31:0] pc;
        bit [31:0] ram_base;
        bit [7:0]  mem  [MEMB];
        bit        seen [MEMB];
        t_out_item awaited [$];
        int        errors;
        int        n_checked;
        int        n_faults;
        int        n_stores;
        int        n_preloads;
        int        n_writes;

        function new();
            ram_base = RAM_BASE_RST;
            pc       = START_PC_RST;
            foreach (regs[i]) regs[i] = '0;
            foreach (seen[i]) seen[i] = 1'b0;
        endfunction

        function void write_cfg(logic [CFG_IDX_W-1:0] idx, bit [31:0] val);
            if (idx == CFG_RAM_BASE) ram_base = val;
            else if (idx == CFG_START_PC) pc = val;
        endfunction

        // byte offset into data memory; zero return when the access leaves it
        function bit mem_off(bit [31:0] addr, int size, output int off);
            bit [32:0] o;
            o   = {1'b0, addr - ram_base};
            off = int'(o[31:0]);
            return (o + 33'(size)) <= 33'(MEMB);
        endfunction

        function int load_size(bit [2:0] f3);
            return (f3[1:0] == 2'd0) ? 1 : ((f3[1:0] == 2'd1) ? 2 : 4);
        endfunction

        // true for a legal in-range load touching a byte never written
        function bit reads_unwritten(bit [31:0] ins);
            bit [2:0]  f3;
            bit [31:0] addr;
            int        off;
            int        sz;
            f3 = ins[14:12];
            if (ins[6:0] != OP_LOAD || f3 == 3'd3 || f3 > 3'd5) return 1'b0;
            addr = regs[ins[19:15]] + {{20{ins[31]}}, ins[31:20]};
            sz   = load_size(f3);
            if (!mem_off(addr, sz, off)) return 1'b0;
            for (int i = 0; i < sz; i++)
                if (!seen[off + i]) return 1'b1;
            return 1'b0;
        endfunction

        function bit [31:0] alu_calc(bit [2:0] f3, bit [6:0] f7, bit rtype,
                                     bit [31:0] a, bit [31:0] b, output bit ok);
            bit [4:0] s;
            s  = b[4:0];
            ok = 1'b1;
            if (rtype && f7 != F7_ZERO && !(f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5))) begin
                ok = 1'b0;
                return '0;
            end
            case (f3)
                3'd0: return (rtype && f7 == F7_ALT) ? a - b : a + b;
                3'd1: begin
                    if (!rtype && f7 != F7_ZERO) begin
                        ok = 1'b0;
                        return '0;
                    end
                    return a << s;
                end
                3'd2: return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                3'd3: return (a < b) ? 32'd1 : 32'd0;
                3'd4: return a ^ b;
                3'd5: begin
                    if (!rtype && f7 != F7_ZERO && f7 != F7_ALT) begin
                        ok = 1'b0;
                        return '0;
                    end
                    return (f7 == F7_ALT) ? 32'($signed(a) >>> s) : a >> s;
                end
                3'd6: return a | b;
                default: return a & b;
            endcase
        endfunction

        // advance the shadow by one transaction and queue its result
        function void note_input(t_in_item it);
            t_out_item r;
            bit [31:0] ins, a, b, immi, imms, immb, immj, val, nxt;
            bit [6:0]  op;
            bit [4:0]  rd;
            bit [2:0]  f3;
            bit        wr, stored, ok, taken;
            bit [1:0]  flt;
            int        off, sz;
            r      = '0;
            nxt    = pc;
            wr     = 1'b0;
            stored = 1'b0;
            flt    = FLT_NONE;
            val    = '0;
            if (it.mode) begin
                for (int i = 0; i < 4; i++) begin
                    mem[it.preload_index * 4 + i]  = it.preload_word[8*i +: 8];
                    seen[it.preload_index * 4 + i] = 1'b1;
                end
                n_preloads++;
            end else begin
                ins  = it.instruction;
                op   = ins[6:0];
                rd   = ins[11:7];
                f3   = ins[14:12];
                a    = regs[ins[19:15]];
                b    = regs[ins[24:20]];
                immi = {{20{ins[31]}}, ins[31:20]};
                imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
                immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
                immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
                nxt  = pc + 32'd4;
                case (op)
                    OP_LUI: begin
                        val = {ins[31:12], 12'd0};
                        wr  = 1'b1;
                    end
                    OP_AUIPC: begin
                        val = pc + {ins[31:12], 12'd0};
                        wr  = 1'b1;
                    end
                    OP_JAL: begin
                        val = pc + 32'd4;
                        wr  = 1'b1;
                        nxt = pc + immj;
                    end
                    OP_JALR: begin
                        if (f3 != 3'd0) flt = FLT_ILL;
                        else begin
                            val = pc + 32'd4;
                            wr  = 1'b1;
                            nxt = (a + immi) & ~32'd1;
                        end
                    end
                    OP_BRANCH: begin
                        taken = 1'b0;
                        case (f3)
                            3'd0: taken = (a == b);
                            3'd1: taken = (a != b);
                            3'd4: taken = $signed(a) < $signed(b);
                            3'd5: taken = !($signed(a) < $signed(b));
                            3'd6: taken = (a < b);
                            3'd7: taken = (a >= b);
                            default: flt = FLT_ILL;
                        endcase
                        if (taken) nxt = pc + immb;
                    end
                    OP_LOAD: begin
                        sz = load_size(f3);
                        if (f3 == 3'd3 || f3 > 3'd5) flt = FLT_ILL;
                        else if (!mem_off(a + immi, sz, off)) flt = FLT_ADDR;
                        else begin
                            for (int i = 0; i < sz; i++) val |= 32'(mem[off + i]) << (8 * i);
                            if (f3 < 3'd3 && sz == 1) val = {{24{val[7]}}, val[7:0]};
                            if (f3 < 3'd3 && sz == 2) val = {{16{val[15]}}, val[15:0]};
                            wr = 1'b1;
                        end
                    end
                    OP_STORE: begin
                        sz = load_size(f3);
                        if (f3 > 3'd2) flt = FLT_ILL;
                        else if (!mem_off(a + imms, sz, off)) flt = FLT_ADDR;
                        else begin
                            for (int i = 0; i < sz; i++) begin
                                mem[off + i]  = b[8*i +: 8];
                                seen[off + i] = 1'b1;
                            end
                            stored = 1'b1;
                        end
                    end
                    OP_IMM: begin
                        val = alu_calc(f3, ins[31:25], 1'b0, a, immi, ok);
                        if (!ok) flt = FLT_ILL;
                        else wr = 1'b1;
                    end
                    OP_REG: begin
                        val = alu_calc(f3, ins[31:25], 1'b1, a, b, ok);
                        if (!ok) flt = FLT_ILL;
                        else wr = 1'b1;
                    end
                    OP_FENCE, OP_SYSTEM: ;
                    default: flt = FLT_ILL;
                endcase
                if (flt != FLT_NONE) begin
                    nxt    = pc;
                    wr     = 1'b0;
                    stored = 1'b0;
                    n_faults++;
                end
                if (rd == 5'd0) wr = 1'b0;
                if (wr) begin
                    regs[rd] = val;
                    n_writes++;
                end
                if (stored) n_stores++;
                pc = nxt;
                r.reg_written = wr;
                r.dest_index  = wr ? rd : 5'd0;
                r.dest_value  = wr ? val : 32'd0;
                r.store_done  = stored;
                r.fault       = flt;
            end
            r.next_pc = nxt;
            awaited.push_back(r);
        endfunction

        task report(string what, bit [31:0] got, bit [31:0] want);
            $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (awaited.size() == 0) begin
                report("unexpected result transaction", got.next_pc, 32'd0);
                return;
            end
            want = awaited.pop_front();
            n_checked++;
            if (got.next_pc != want.next_pc) report("next_pc", got.next_pc, want.next_pc);
            if (got.reg_written != want.reg_written)
                report("reg_written", got.reg_written, want.reg_written);
            if (got.dest_index != want.dest_index)
                report("dest_index", got.dest_index, want.dest_index);
            if (got.dest_value != want.dest_value)
                report("dest_value", got.dest_value, want.dest_value);
            if (got.store_done != want.store_done)
                report("store_done", got.store_done, want.store_done);
            if (got.fault != want.fault) report("fault", got.fault, want.fault);
        endtask
    endclass

    // ------------------------------------------------------------------
    // clock, reset and the unit under test
    // ------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out_item;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [31:0]           i_cfg_wdata;

    exec_scoreboard sb = new();

    bit running    = 1'b0;   // watchdog armed once reset is released
    bit hold_req   = 1'b0;   // asks the receiver for a long stall
    bit no_gaps    = 1'b0;   // sender runs back to back when set
    int burst_left = 0;
    int idle_cycles = 0;

    rv32i_integer_execute_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // instruction encoders
    // ------------------------------------------------------------------
    function automatic bit [31:0] enc_i(bit [6:0] op, bit [2:0] f3, bit [4:0] rd,
                                        bit [4:0] rs1, bit [11:0] imm);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic bit [31:0] enc_r(bit [6:0] f7, bit [2:0] f3, bit [4:0] rd,
                                        bit [4:0] rs1, bit [4:0] rs2);
        return {f7, rs2, rs1, f3, rd, OP_REG};
    endfunction

    function automatic bit [31:0] enc_s(bit [2:0] f3, bit [4:0] rs1, bit [4:0] rs2,
                                        bit [11:0] imm);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction

    function automatic bit [31:0] enc_b(bit [2:0] f3, bit [4:0] rs1, bit [4:0] rs2,
                                        bit [12:0] imm);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
    endfunction

    function automatic bit [31:0] enc_j(bit [4:0] rd, bit [20:0] imm);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
    endfunction

    // execute transaction; unused preload fields carry noise
    function automatic t_in_item exec_item(bit [31:0] ins);
        t_in_item it;
        it.mode          = 1'b0;
        it.instruction   = ins;
        it.preload_index = 10'($urandom);
        it.preload_word  = $urandom;
        return it;
    endfunction

    function automatic t_in_item preload_item(bit [9:0] idx, bit [31:0] w);
        t_in_item it;
        it.mode          = 1'b1;
        it.instruction   = $urandom;
        it.preload_index = idx;
        it.preload_word  = w;
        return it;
    endfunction

    // destination mostly spares the two pointer registers
    function automatic bit [4:0] pick_rd();
        bit [4:0] rd;
        rd = 5'($urandom_range(0, 31));
        if ((rd == 5'd1 || rd == 5'd2) && $urandom_range(0, 7) != 0) rd = rd + 5'd2;
        return rd;
    endfunction

    // memory base: x1 sits mid-memory, x2 near the top edge
    function automatic bit [4:0] pick_base(output bit [11:0] imm);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            imm = 12'($urandom);
            return 5'd1;
        end else if (sel < 9) begin
            imm = 12'($urandom_range(0, 72) - 64);
            return 5'd2;
        end
        imm = 12'($urandom);
        return 5'($urandom_range(0, 31));
    endfunction

    function automatic t_in_item random_item();
        int        k;
        bit [4:0]  rd, rs1, rs2;
        bit [2:0]  f3;
        bit [11:0] imm;
        bit [6:0]  f7;
        k   = $urandom_range(0, 99);
        rd  = pick_rd();
        rs1 = 5'($urandom_range(0, 31));
        rs2 = 5'($urandom_range(0, 31));
        f3  = 3'($urandom);
        imm = 12'($urandom);
        if (k < 14) begin
            // alu with immediate, shifts mostly well formed
            if (f3 == 3'd1 && $urandom_range(0, 7) != 0) imm[11:5] = F7_ZERO;
            if (f3 == 3'd5 && $urandom_range(0, 7) != 0)
                imm[11:5] = $urandom_range(0, 1) ? F7_ALT : F7_ZERO;
            return exec_item(enc_i(OP_IMM, f3, rd, rs1, imm));
        end else if (k < 28) begin
            f7 = $urandom_range(0, 1) ? F7_ALT : F7_ZERO;
            if ($urandom_range(0, 9) == 0) f7 = 7'($urandom);
            return exec_item(enc_r(f7, f3, rd, rs1, rs2));
        end else if (k < 44) begin
            if ($urandom_range(0, 9) != 0) f3 = 3'($urandom_range(0, 4) > 2 ?
                                                   $urandom_range(4, 5) : $urandom_range(0, 2));
            rs1 = pick_base(imm);
            return exec_item(enc_i(OP_LOAD, f3, rd, rs1, imm));
        end else if (k < 60) begin
            if ($urandom_range(0, 9) != 0) f3 = 3'($urandom_range(0, 2));
            rs1 = pick_base(imm);
            return exec_item(enc_s(f3, rs1, rs2, imm));
        end else if (k < 68) begin
            return exec_item(enc_b(f3, rs1, rs2, 13'($urandom)));
        end else if (k < 71) begin
            return exec_item(enc_j(rd, 21'($urandom)));
        end else if (k < 74) begin
            if ($urandom_range(0, 5) != 0) f3 = 3'd0;
            return exec_item(enc_i(OP_JALR, f3, rd, rs1, imm));
        end else if (k < 78) begin
            return exec_item({20'($urandom), rd, $urandom_range(0, 1) ? OP_LUI : OP_AUIPC});
        end else if (k < 80) begin
            return exec_item({25'($urandom), $urandom_range(0, 1) ? OP_FENCE : OP_SYSTEM});
        end else if (k < 86) begin
            return exec_item($urandom);
        end
        return preload_item(10'($urandom), $urandom);
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    // offers one transaction, with burst gaps before it; returns once accepted
    task automatic send(t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            burst_left = $urandom_range(1, 40);
            if (gap != 0) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        // a load from a never-written location becomes a store to it instead
        if (!it.mode && sb.reads_unwritten(it.instruction))
            it.instruction = enc_s({1'b0, it.instruction[13:12]}, it.instruction[19:15],
                                   5'($urandom), it.instruction[31:20]);
        i_in_valid = 1'b1;
        i_in_item  = it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(it);
        burst_left--;
    endtask

    task automatic set_reg(bit [4:0] r, bit [31:0] v);
        bit [31:0] hi;
        hi = v + 32'h800;
        send(exec_item({hi[31:12], r, OP_LUI}));
        send(exec_item(enc_i(OP_IMM, 3'd0, r, r, v[11:0])));
    endtask

    task automatic set_pointers();
        set_reg(5'd1, sb.ram_base + 32'h800);
        set_reg(5'd2, sb.ram_base + 32'(MEMB - 4));
    endtask

    // lowers valid and waits until every awaited result is back
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, bit [31:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        sb.write_cfg(idx, val);
    endtask

    task automatic random_run(int count, int hold_at, int pause_at);
        for (int n = 0; n < count; n++) begin
            if (n % 48 == 47) set_pointers();
            if (n % 150 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            if (n == hold_at) hold_req = 1'b1;
            if (n == pause_at) drain();
            send(random_item());
        end
    endtask

    // ------------------------------------------------------------------
    // receiver: ready always high, random or mostly low, redrawn by a loop counter; long hold on request
    // ------------------------------------------------------------------
    initial begin
        int pattern;
        int cnt;
        i_out_ready = 1'b0;
        pattern     = 0;
        cnt         = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready = 1'b0;
                repeat (HOLD_LEN) @(negedge i_clk);
                hold_req = 1'b0;
            end
            if (cnt % 50 == 0) pattern = $urandom_range(0, 2);
            cnt++;
            case (pattern)
                0: i_out_ready = 1'b1;
                1: i_out_ready = $urandom_range(0, 1);
                default: i_out_ready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result monitor and no-progress watchdog
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) sb.check_result(o_out_item);
        if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready) || !running)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_RAM_BASE;
        i_cfg_wdata = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        running = 1'b1;

        // directed: memory edges, sign extension, jumps, faults, x0
        set_pointers();
        send(preload_item(10'd0, 32'h8081_F0F7));
        send(preload_item(10'd1023, 32'hFEDC_8A98));
        send(exec_item(enc_i(OP_LOAD, 3'd0, 5'd3, 5'd1, 12'h800)));   // lb, lowest byte
        send(exec_item(enc_i(OP_LOAD, 3'd4, 5'd4, 5'd1, 12'h801)));   // lbu
        send(exec_item(enc_i(OP_LOAD, 3'd1, 5'd5, 5'd1, 12'h7FE)));   // lh, top half
        send(exec_item(enc_i(OP_LOAD, 3'd5, 5'd6, 5'd1, 12'h7FE)));   // lhu
        send(exec_item(enc_i(OP_LOAD, 3'd2, 5'd7, 5'd1, 12'h7FE)));   // lw past the end
        send(exec_item(enc_s(3'd2, 5'd1, 5'd5, 12'h001)));            // misaligned sw
        send(exec_item(enc_i(OP_LOAD, 3'd2, 5'd8, 5'd1, 12'h001)));
        send(exec_item(enc_i(OP_IMM, 3'd2, 5'd9, 5'd5, 12'hFFF)));    // slti signed
        send(exec_item(enc_r(F7_ALT, 3'd5, 5'd10, 5'd5, 5'd3)));      // sra
        send(exec_item(enc_r(F7_ALT, 3'd0, 5'd11, 5'd0, 5'd5)));      // sub
        send(exec_item(enc_i(OP_IMM, 3'd0, 5'd0, 5'd5, 12'h123)));    // x0 stays zero
        send(exec_item({20'hFFFFF, 5'd12, OP_AUIPC}));
        send(exec_item(enc_b(3'd4, 5'd5, 5'd0, 13'h1FFC)));           // blt taken back
        send(exec_item(enc_j(5'd13, 21'h0FFFFE)));
        send(exec_item(enc_i(OP_JALR, 3'd0, 5'd14, 5'd5, 12'h7FF)));  // odd target
        send(exec_item(enc_i(OP_JALR, 3'd1, 5'd14, 5'd5, 12'h000)));  // illegal funct3
        send(exec_item({25'd0, OP_FENCE}));
        send(exec_item({25'd1 << 13, OP_SYSTEM}));                    // ebreak
        send(exec_item(32'hFFFF_FFFF));                               // unknown opcode
        random_run(260, -1, -1);
        drain();

        // low addresses
        cfg_write(CFG_RAM_BASE, 32'h0000_0000);
        cfg_write(CFG_START_PC, 32'h0000_0000);
        set_pointers();
        random_run(270, -1, 130);
        drain();

        // memory window ending at the top of the address space, pc about to wrap
        cfg_write(CFG_RAM_BASE, 32'hFFFF_F000);
        cfg_write(CFG_START_PC, 32'hFFFF_FFFC);
        set_pointers();
        random_run(270, 100, -1);
        drain();

        cfg_write(CFG_RAM_BASE, $urandom);
        cfg_write(CFG_START_PC, $urandom);
        set_pointers();
        random_run(270, -1, -1);
        drain();

        $display("checked %0d results: %0d faults, %0d register writes, %0d stores, %0d preloads",
                 sb.n_checked, sb.n_faults, sb.n_writes, sb.n_stores, sb.n_preloads);
        $display("covered four base/pc settings incl. zero and a wrapping memory window");
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
